// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define TMSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TMSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tmsa_pkg.sv -----
// Types and constants of the trimmed mean sample averager.
`default_nettype none

package tmsa_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 7;
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS    = $clog2(SUM_BITS);
  localparam int SETTLE_COUNT = 4;
  localparam int TRIM_OFFSET  = 6;
  localparam int MIN_COUNT    = 7;
  localparam int RESET_COUNT  = 20;

  typedef struct packed {
    logic accept;
    logic load_div;
    logic div_step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic is_last;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/tmsa_channel_if.sv -----
// Valid/ready channel interfaces for samples and averages.
`default_nettype none

interface tmsa_sample_if;
  logic                             valid;
  logic                             ready;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tmsa_average_if;
  logic                             valid;
  logic                             ready;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] average;
  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmsa_ctrl.sv -----
// Controller: sequences sample intake, trim, division and result hand-off.
`default_nettype none
`include "assert_macros.svh"

module tmsa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire tmsa_pkg::sts_t sts,
  output tmsa_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRIM = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.load_div  = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.write_out = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.is_last) begin
          state_next = S_TRIM;
        end
      end
      S_TRIM: begin
        cmd.load_div = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // The previous average may still be waiting on the output side.
        if (out_free) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TMSA_ASSERT(a_no_overwrite, cmd.write_out |-> (!out_valid || out_ready), "average overwritten")
  `TMSA_ASSERT(a_trim_then_div, state == S_TRIM |=> state == S_DIV, "trim not followed by divide")

endmodule

`default_nettype wire

// ----- rtl/tmsa_datapath.sv -----
// Datapath: block count register, sum and extremes, and the serial divider.
`default_nettype none
`include "assert_macros.svh"

module tmsa_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tmsa_pkg::COUNT_BITS-1:0]  cfg_wdata,
  input  wire logic [tmsa_pkg::SAMPLE_BITS-1:0] sample,
  input  wire tmsa_pkg::cmd_t                   cmd,
  output tmsa_pkg::sts_t                        sts,
  output logic [tmsa_pkg::SAMPLE_BITS-1:0]      average
);

  localparam int CB = tmsa_pkg::COUNT_BITS;
  localparam int SB = tmsa_pkg::SAMPLE_BITS;
  localparam int WB = tmsa_pkg::SUM_BITS;
  localparam int TB = tmsa_pkg::STEP_BITS;

  logic [CB-1:0] block_count;
  logic [CB-1:0] sample_index;
  logic [WB-1:0] running_sum;
  logic [SB-1:0] largest_seen;
  logic [SB-1:0] smallest_seen;
  logic [WB-1:0] quotient;
  logic [CB-1:0] remainder;
  logic [CB-1:0] divisor;
  logic [TB-1:0] step;

  logic [CB:0]   index_inc;
  logic          settled;
  logic [SB:0]   extremes;
  logic [WB-1:0] extremes_wide;
  logic [WB-1:0] trimmed;
  logic [CB:0]   trial;
  logic [CB:0]   trial_diff;
  logic          fits;
  logic          saturate;
  logic [CB-1:0] cfg_clamped;

  assign index_inc     = {1'b0, sample_index} + (CB+1)'(1);
  assign sts.is_last   = index_inc >= {1'b0, block_count};
  assign settled       = sample_index >= CB'(tmsa_pkg::SETTLE_COUNT);
  assign extremes      = {1'b0, largest_seen} + {1'b0, smallest_seen};
  assign extremes_wide = WB'(extremes);
  assign trimmed       = (running_sum >= extremes_wide) ? running_sum - extremes_wide : '0;
  assign cfg_clamped   = (cfg_wdata < CB'(tmsa_pkg::MIN_COUNT)) ?
                         CB'(tmsa_pkg::MIN_COUNT) : cfg_wdata;

  // Restoring division, one quotient bit per step, dividend bits shift out of the top.
  assign trial        = {remainder, quotient[WB-1]};
  assign fits         = trial >= {1'b0, divisor};
  assign trial_diff   = trial - {1'b0, divisor};
  assign sts.div_last = (step == TB'(WB - 1));
  assign saturate     = |quotient[WB-1:SB];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= CB'(tmsa_pkg::RESET_COUNT);
      sample_index  <= '0;
      running_sum   <= '0;
      largest_seen  <= '0;
      smallest_seen <= '1;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_clamped;
      end
      if (cmd.accept) begin
        if (settled) begin
          running_sum <= running_sum + WB'(sample);
          if (sample > largest_seen) begin
            largest_seen <= sample;
          end
          if (sample < smallest_seen) begin
            smallest_seen <= sample;
          end
        end
        if (!sts.is_last) begin
          sample_index <= index_inc[CB-1:0];
        end
      end
      if (cmd.load_div) begin
        sample_index  <= '0;
        running_sum   <= '0;
        largest_seen  <= '0;
        smallest_seen <= '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quotient  <= trimmed;
      remainder <= '0;
      divisor   <= block_count - CB'(tmsa_pkg::TRIM_OFFSET);
      step      <= '0;
    end
    if (cmd.div_step) begin
      quotient  <= {quotient[WB-2:0], fits};
      remainder <= fits ? trial_diff[CB-1:0] : trial[CB-1:0];
      step      <= step + TB'(1);
    end
    if (cmd.write_out) begin
      average <= saturate ? '1 : quotient[SB-1:0];
    end
  end

  `TMSA_ASSERT(a_count_legal, block_count >= CB'(tmsa_pkg::MIN_COUNT), "block count below minimum")
  `TMSA_ASSERT(a_settle_clear,
    settled == 1'b0 |-> (running_sum == '0 && largest_seen == '0 && smallest_seen == '1),
    "settling samples reached the accumulators")
  `TMSA_ASSERT(a_rem_bound, cmd.div_step |-> remainder < divisor, "divider remainder out of range")

endmodule

`default_nettype wire

// ----- rtl/trimmed_mean_sample_averager.sv -----
// Trimmed mean averager: sum of settled samples less max and min, over count minus six.
// Timing: a non-final sample is accepted while idle; the final sample of a block leads to
// its average in the output register through trim, a 23-step divide and the load, in that order.
// Intake: no sample is taken until that average is loaded; the load waits for the previous one.
// Reset (rst, synchronous): block count 20, index and sum zero, extremes cleared, no output.
`default_nettype none

module trimmed_mean_sample_averager (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tmsa_pkg::COUNT_BITS-1:0] cfg_wdata,
  tmsa_sample_if.sink                          sample_ch,
  tmsa_average_if.source                       average_ch
);

  tmsa_pkg::cmd_t cmd;
  tmsa_pkg::sts_t sts;

  tmsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (average_ch.valid),
    .out_ready (average_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch.sample),
    .cmd       (cmd),
    .sts       (sts),
    .average   (average_ch.average)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the trimmed mean averager: random sample blocks and count changes.
module tb;

  localparam int SAMPLE_BITS  = tmsa_pkg::SAMPLE_BITS;
  localparam int COUNT_BITS   = tmsa_pkg::COUNT_BITS;
  localparam int SUM_BITS     = tmsa_pkg::SUM_BITS;
  localparam int SETTLE_COUNT = tmsa_pkg::SETTLE_COUNT;
  localparam int TRIM_OFFSET  = tmsa_pkg::TRIM_OFFSET;
  localparam int MIN_COUNT    = tmsa_pkg::MIN_COUNT;
  localparam int RESET_COUNT  = tmsa_pkg::RESET_COUNT;

  localparam int DONE_LATENCY  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SAMPLE_TARGET = 650;

  typedef enum logic [1:0] {SEND_SAMPLE, WRITE_COUNT, WAIT_IDLE} stim_kind_t;

  typedef struct {
    stim_kind_t             kind;
    logic [SAMPLE_BITS-1:0] value;
    int                     gap;
  } stim_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [COUNT_BITS-1:0] cfg_wdata;

  tmsa_sample_if  sample_ch();
  tmsa_average_if average_ch();

  trimmed_mean_sample_averager u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sample_ch  (sample_ch),
    .average_ch (average_ch)
  );

  stim_t                  pending[$];
  logic [SAMPLE_BITS-1:0] averages_due[$];
  int                     fail_count;
  int                     cycle_count;
  logic                   sample_taken;
  int                     gap_left;
  int                     settle_left;
  int                     stall_left;
  int                     calm_left;

  // Local copy of the averager state.
  int                     count_setting;
  int                     block_pos;
  logic [SUM_BITS-1:0]    settled_sum;
  logic [SAMPLE_BITS-1:0] peak_hi;
  logic [SAMPLE_BITS-1:0] peak_lo;

  function automatic void clear_block();
    block_pos   = 0;
    settled_sum = '0;
    peak_hi     = '0;
    peak_lo     = '1;
  endfunction

  // Folds one sample into the block; returns 1 when it closes the block.
  function automatic bit fold_sample(input logic [SAMPLE_BITS-1:0] s,
                                     output logic [SAMPLE_BITS-1:0] mean);
    int extremes;
    int trimmed;
    int quotient;
    mean = '0;
    if (block_pos >= SETTLE_COUNT) begin
      settled_sum = settled_sum + SUM_BITS'(s);
      if (s > peak_hi) peak_hi = s;
      if (s < peak_lo) peak_lo = s;
    end
    if (block_pos + 1 < count_setting) begin
      block_pos++;
      return 1'b0;
    end
    extremes = int'(peak_hi) + int'(peak_lo);
    trimmed  = (int'(settled_sum) >= extremes) ? int'(settled_sum) - extremes : 0;
    quotient = trimmed / (count_setting - TRIM_OFFSET);
    // Only a count lowered mid-block can push the mean past full scale.
    mean = (quotient > int'({SAMPLE_BITS{1'b1}})) ? '1 : quotient[SAMPLE_BITS-1:0];
    clear_block();
    return 1'b1;
  endfunction

  function automatic int pick_gap(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 19))
      10, 11, 12, 13, 14, 15, 16: return $urandom_range(1, 3);
      17, 18:                     return $urandom_range(4, 10);
      19:                         return $urandom_range(20, 40);
      default:                    return 0;
    endcase
  endfunction

  function automatic void queue_sample(logic [SAMPLE_BITS-1:0] v, bit calm);
    pending.push_back('{kind: SEND_SAMPLE, value: v, gap: pick_gap(calm)});
  endfunction

  function automatic void queue_count(int raw);
    pending.push_back('{kind: WRITE_COUNT, value: SAMPLE_BITS'(raw), gap: 0});
  endfunction

  function automatic void queue_pause();
    pending.push_back('{kind: WAIT_IDLE, value: '0, gap: 0});
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(int style,
                                                         logic [SAMPLE_BITS-1:0] center);
    case (style)
      0:       return SAMPLE_BITS'($urandom);
      1:       return center ^ SAMPLE_BITS'($urandom_range(0, 255));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return SAMPLE_BITS'($urandom_range(65000, 65535));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample driver: a beat stays up until taken, then the item's gap follows.
  always @(negedge clk) begin
    logic                   next_valid;
    logic [SAMPLE_BITS-1:0] next_sample;
    logic                   next_we;
    if (!rst) begin
      next_valid  = sample_ch.valid && !sample_taken;
      next_sample = next_valid ? sample_ch.sample : SAMPLE_BITS'($urandom);
      next_we     = 1'b0;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          if (pending[0].kind == SEND_SAMPLE) begin
            next_valid  = 1'b1;
            next_sample = pending[0].value;
            gap_left    = pending[0].gap;
            settle_left = DONE_LATENCY;
            void'(pending.pop_front());
          end else if (averages_due.size() != 0) begin
            settle_left = DONE_LATENCY;
          end else if (settle_left > 0) begin
            settle_left--;
          end else begin
            if (pending[0].kind == WRITE_COUNT) begin
              next_we       = 1'b1;
              cfg_wdata     <= pending[0].value[COUNT_BITS-1:0];
              count_setting = int'(pending[0].value[COUNT_BITS-1:0]);
              if (count_setting < MIN_COUNT) count_setting = MIN_COUNT;
            end
            settle_left = DONE_LATENCY;
            void'(pending.pop_front());
          end
        end
      end
      sample_ch.valid  <= next_valid;
      sample_ch.sample <= next_sample;
      cfg_we           <= next_we;
    end
  end

  // Average sink: random stalls, with calm stretches where no new stall starts.
  always @(negedge clk) begin
    if (!rst) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 199) == 0) begin
        calm_left = $urandom_range(50, 300);
      end
      if (stall_left > 0) begin
        stall_left--;
        average_ch.ready <= 1'b0;
      end else begin
        average_ch.ready <= 1'b1;
        if (calm_left == 0) begin
          case ($urandom_range(0, 19))
            0, 1, 2: stall_left = $urandom_range(1, 3);
            3:       stall_left = $urandom_range(20, 60);
            default: ;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_BITS-1:0] mean;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_ch.valid && sample_ch.ready;
      if (sample_ch.valid && sample_ch.ready) begin
        if (fold_sample(sample_ch.sample, mean)) averages_due.push_back(mean);
      end
      if (average_ch.valid && average_ch.ready) begin
        if (averages_due.size() == 0) begin
          $error("average: none expected, got %0d", average_ch.average);
          fail_count++;
        end else begin
          if (average_ch.average !== averages_due[0]) begin
            $error("average: expected %0d, got %0d", averages_due[0], average_ch.average);
            fail_count++;
          end
          void'(averages_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("trimmed_mean_sample_averager test failed");
      $finish;
    end
  end

  initial begin
    int                     sent;
    int                     raw;
    int                     len;
    int                     style;
    bit                     calm;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] pattern[$];

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    average_ch.ready = 1'b0;
    sample_taken     = 1'b0;
    fail_count       = 0;
    cycle_count      = 0;
    gap_left         = 0;
    settle_left      = DONE_LATENCY;
    stall_left       = 0;
    calm_left        = 0;
    count_setting    = RESET_COUNT;
    clear_block();

    // Full-scale samples at the reset count, then the count is cut below the
    // minimum mid-block: the next sample closes the block with a saturated mean.
    repeat (10) queue_sample('1, 1'b0);
    queue_count(6);
    queue_sample('1, 1'b0);
    pattern = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000};
    foreach (pattern[i]) queue_sample(pattern[i], 1'b0);
    pattern = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFE, 16'h7FFF};
    foreach (pattern[i]) queue_sample(pattern[i], 1'b0);
    queue_pause();
    sent = 25;

    while (sent < SAMPLE_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0:       raw = 127;
        1:       raw = $urandom_range(0, 6);
        2:       raw = $urandom_range(7, 127);
        3:       raw = 7;
        default: raw = $urandom_range(7, 16);
      endcase
      queue_count(raw);
      len = (raw < MIN_COUNT) ? MIN_COUNT : raw;
      repeat ((len > 40) ? 1 : $urandom_range(1, 4)) begin
        style  = $urandom_range(0, 4);
        center = SAMPLE_BITS'($urandom);
        repeat (len) queue_sample(draw_sample(style, center), calm);
        sent += len;
      end
      // A partial block left open, so the next count write lands mid-block.
      if ($urandom_range(0, 4) == 0) begin
        style  = $urandom_range(0, 4);
        center = SAMPLE_BITS'($urandom);
        raw    = $urandom_range(1, len - 1);
        repeat (raw) queue_sample(draw_sample(style, center), calm);
        sent += raw;
      end
      if ($urandom_range(0, 7) == 0) queue_pause();
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || sample_ch.valid || averages_due.size() != 0)
      @(posedge clk);
    repeat (DONE_LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("trimmed_mean_sample_averager test passed");
    end else begin
      $display("trimmed_mean_sample_averager test failed");
    end
    $finish;
  end

endmodule

// ----- trimmed_mean_sample_averager.f -----
+incdir+rtl
rtl/tmsa_pkg.sv
rtl/tmsa_channel_if.sv
rtl/tmsa_ctrl.sv
rtl/tmsa_datapath.sv
rtl/trimmed_mean_sample_averager.sv
tb/tb.sv
